// ===== rtl/rmq_pkg.sv =====
// Types, constants and per-step helpers for the rotation matrix to quaternion pipeline.
// No dependencies; used by rotation_matrix_to_quaternion_top.
package rmq_pkg;

    localparam int ONE_Q14    = 16384;
    localparam int SQ_STAGES  = 15;   // one root bit per stage
    localparam int DIV_STAGES = 15;   // one quotient bit per stage

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_out;

    // branch codes, also the index of the dominant component
    localparam logic [1:0] DOM_W = 2'd0;
    localparam logic [1:0] DOM_X = 2'd1;
    localparam logic [1:0] DOM_Y = 2'd2;
    localparam logic [1:0] DOM_Z = 2'd3;

    typedef struct packed {
        logic [29:0] rad;
        logic [18:0] rem;
        logic [14:0] root;
    } t_sq;

    // one digit of the restoring square root, top two radicand bits consumed
    function automatic t_sq sq_step(t_sq s);
        t_sq         o;
        logic [18:0] r2;
        logic [18:0] trial;
        r2    = {s.rem[16:0], s.rad[29:28]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[27:0], 2'b00};
        if (r2 >= trial) begin
            o.rem  = r2 - trial;
            o.root = {s.root[13:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[13:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Throughput: one matrix per cycle; busy is never raised.
// Stages: input register, branch select, 15 root stages, divisor setup,
// 15 quotient stages per component, output clamp register.
// Synchronous active-low reset clears the valid bits only; payload is not reset.
// Results cannot be held off by the receiver.
module rotation_matrix_to_quaternion_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rmq_pkg::t_in   i_in,
    output logic           o_done,
    output rmq_pkg::t_out  o_quat
);

    // input register
    logic          r_in_v;
    rmq_pkg::t_in  r_in;

    // root pipeline
    logic                r_sq_v    [0:rmq_pkg::SQ_STAGES];
    rmq_pkg::t_sq        r_sq      [0:rmq_pkg::SQ_STAGES];
    logic [1:0]          r_sq_dom  [0:rmq_pkg::SQ_STAGES];
    logic                r_sq_zero [0:rmq_pkg::SQ_STAGES];
    logic signed [17:0]  r_sq_n    [0:rmq_pkg::SQ_STAGES][0:3];

    // divider pipeline, four lanes
    logic                r_dv_v    [0:rmq_pkg::DIV_STAGES];
    logic [1:0]          r_dv_dom  [0:rmq_pkg::DIV_STAGES];
    logic                r_dv_zero [0:rmq_pkg::DIV_STAGES];
    logic [14:0]         r_dv_big  [0:rmq_pkg::DIV_STAGES];
    logic [30:0]         r_dv_rem  [0:rmq_pkg::DIV_STAGES][0:3];
    logic [14:0]         r_dv_q    [0:rmq_pkg::DIV_STAGES][0:3];
    logic                r_dv_neg  [0:rmq_pkg::DIV_STAGES][0:3];
    logic                r_dv_ovf  [0:rmq_pkg::DIV_STAGES][0:3];

    logic          r_out_v;
    logic          r_out_zero;
    rmq_pkg::t_out r_out;

    // branch select
    logic signed [17:0] rx, uy, fz;
    logic signed [18:0] n_t, n_r;
    logic [1:0]         n_dom;
    logic signed [17:0] n_n [0:3];

    always_comb begin
        rx  = 18'(r_in.right_x);
        uy  = 18'(r_in.up_y);
        fz  = 18'(r_in.fwd_z);
        n_t = 19'(rx) + 19'(uy) + 19'(fz);
        n_n[0] = 18'(r_in.up_z) - 18'(r_in.fwd_y);
        n_n[1] = 18'(r_in.fwd_x) - 18'(r_in.right_z);
        n_n[2] = 18'(r_in.right_y) - 18'(r_in.up_x);
        n_n[3] = '0;
        if (n_t > 19'sd16384) begin
            n_dom  = rmq_pkg::DOM_W;
            n_r    = n_t + 19'sd16384;
            n_n[3] = n_n[2];
            n_n[2] = n_n[1];
            n_n[1] = n_n[0];
            n_n[0] = '0;
        end else if (rx > uy && rx > fz) begin
            n_dom  = rmq_pkg::DOM_X;
            n_r    = 19'sd16384 + 19'(rx) - 19'(uy) - 19'(fz);
            n_n[0] = 18'(r_in.up_z) - 18'(r_in.fwd_y);
            n_n[1] = '0;
            n_n[2] = 18'(r_in.right_y) + 18'(r_in.up_x);
            n_n[3] = 18'(r_in.right_z) + 18'(r_in.fwd_x);
        end else if (uy > fz) begin
            n_dom  = rmq_pkg::DOM_Y;
            n_r    = 19'sd16384 + 19'(uy) - 19'(rx) - 19'(fz);
            n_n[0] = 18'(r_in.fwd_x) - 18'(r_in.right_z);
            n_n[1] = 18'(r_in.right_y) + 18'(r_in.up_x);
            n_n[2] = '0;
            n_n[3] = 18'(r_in.up_z) + 18'(r_in.fwd_y);
        end else begin
            n_dom  = rmq_pkg::DOM_Z;
            n_r    = 19'sd16384 + 19'(fz) - 19'(rx) - 19'(uy);
            n_n[0] = 18'(r_in.right_y) - 18'(r_in.up_x);
            n_n[1] = 18'(r_in.right_z) + 18'(r_in.fwd_x);
            n_n[2] = 18'(r_in.up_z) + 18'(r_in.fwd_y);
            n_n[3] = '0;
        end
    end

    // divisor setup from the finished root
    logic [14:0] n_big;
    logic [15:0] n_dv;
    logic [16:0] n_mag [0:3];
    logic [30:0] n_num [0:3];

    always_comb begin
        n_big = r_sq[rmq_pkg::SQ_STAGES].root;
        n_dv  = {n_big, 1'b0};
        for (int l = 0; l < 4; l++) begin
            n_mag[l] = r_sq_n[rmq_pkg::SQ_STAGES][l][17]
                     ? 17'(-r_sq_n[rmq_pkg::SQ_STAGES][l])
                     : 17'(r_sq_n[rmq_pkg::SQ_STAGES][l]);
            n_num[l] = {1'b0, n_mag[l], 13'd0} + 31'(n_big);
        end
    end

    // output clamp and sign
    rmq_pkg::t_out n_out;
    logic [15:0]   n_val [0:3];
    logic [15:0]   n_bigc;

    always_comb begin
        n_bigc = (r_dv_big[rmq_pkg::DIV_STAGES] > 15'd16384)
               ? 16'd16384 : {1'b0, r_dv_big[rmq_pkg::DIV_STAGES]};
        for (int l = 0; l < 4; l++) begin
            if (r_dv_zero[rmq_pkg::DIV_STAGES]) begin
                n_val[l] = '0;
            end else if (r_dv_dom[rmq_pkg::DIV_STAGES] == 2'(l)) begin
                n_val[l] = n_bigc;
            end else begin
                if (r_dv_ovf[rmq_pkg::DIV_STAGES][l]
                        || r_dv_q[rmq_pkg::DIV_STAGES][l] > 15'd16384) begin
                    n_val[l] = 16'd16384;
                end else begin
                    n_val[l] = {1'b0, r_dv_q[rmq_pkg::DIV_STAGES][l]};
                end
                if (r_dv_neg[rmq_pkg::DIV_STAGES][l]) begin
                    n_val[l] = -n_val[l];
                end
            end
        end
        n_out.quat_w = n_val[0];
        n_out.quat_x = n_val[1];
        n_out.quat_y = n_val[2];
        n_out.quat_z = n_val[3];
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= rmq_pkg::SQ_STAGES; k++) r_sq_v[k] <= 1'b0;
            for (int k = 0; k <= rmq_pkg::DIV_STAGES; k++) r_dv_v[k] <= 1'b0;
        end else begin
            r_in_v    <= start;
            r_sq_v[0] <= r_in_v;
            for (int k = 1; k <= rmq_pkg::SQ_STAGES; k++) r_sq_v[k] <= r_sq_v[k-1];
            r_dv_v[0] <= r_sq_v[rmq_pkg::SQ_STAGES];
            for (int k = 1; k <= rmq_pkg::DIV_STAGES; k++) r_dv_v[k] <= r_dv_v[k-1];
            r_out_v   <= r_dv_v[rmq_pkg::DIV_STAGES];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_in <= i_in;

        r_sq[0].rad   <= (n_r > 19'sd0) ? 30'({n_r[16:0], 12'd0}) : '0;
        r_sq[0].rem   <= '0;
        r_sq[0].root  <= '0;
        r_sq_dom[0]   <= n_dom;
        r_sq_zero[0]  <= (n_r <= 19'sd0);
        for (int l = 0; l < 4; l++) r_sq_n[0][l] <= n_n[l];
        for (int k = 1; k <= rmq_pkg::SQ_STAGES; k++) begin
            r_sq[k]      <= rmq_pkg::sq_step(r_sq[k-1]);
            r_sq_dom[k]  <= r_sq_dom[k-1];
            r_sq_zero[k] <= r_sq_zero[k-1];
            for (int l = 0; l < 4; l++) r_sq_n[k][l] <= r_sq_n[k-1][l];
        end

        r_dv_dom[0]  <= r_sq_dom[rmq_pkg::SQ_STAGES];
        r_dv_zero[0] <= r_sq_zero[rmq_pkg::SQ_STAGES];
        r_dv_big[0]  <= n_big;
        for (int l = 0; l < 4; l++) begin
            r_dv_rem[0][l] <= n_num[l];
            r_dv_q[0][l]   <= '0;
            r_dv_neg[0][l] <= r_sq_n[rmq_pkg::SQ_STAGES][l][17];
            r_dv_ovf[0][l] <= (n_num[l] >= {n_dv, 15'd0});
        end
        for (int k = 1; k <= rmq_pkg::DIV_STAGES; k++) begin
            r_dv_dom[k]  <= r_dv_dom[k-1];
            r_dv_zero[k] <= r_dv_zero[k-1];
            r_dv_big[k]  <= r_dv_big[k-1];
            for (int l = 0; l < 4; l++) begin
                r_dv_neg[k][l] <= r_dv_neg[k-1][l];
                r_dv_ovf[k][l] <= r_dv_ovf[k-1][l];
                // quotient bit DIV_STAGES-k against divisor shifted up by that much
                if (r_dv_rem[k-1][l] >= (31'({r_dv_big[k-1], 1'b0})
                        << (rmq_pkg::DIV_STAGES - k))) begin
                    r_dv_rem[k][l] <= r_dv_rem[k-1][l] - (31'({r_dv_big[k-1], 1'b0})
                        << (rmq_pkg::DIV_STAGES - k));
                    r_dv_q[k][l]   <= r_dv_q[k-1][l]
                        | (15'd1 << (rmq_pkg::DIV_STAGES - k));
                end else begin
                    r_dv_rem[k][l] <= r_dv_rem[k-1][l];
                    r_dv_q[k][l]   <= r_dv_q[k-1][l];
                end
            end
        end

        r_out      <= n_out;
        r_out_zero <= r_dv_zero[rmq_pkg::DIV_STAGES];
    end

    assign busy   = 1'b0;
    assign o_done = r_out_v;
    assign o_quat = r_out;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quat.quat_w <= 16'sd16384 && o_quat.quat_w >= -16'sd16384
                 && o_quat.quat_x <= 16'sd16384 && o_quat.quat_x >= -16'sd16384
                 && o_quat.quat_y <= 16'sd16384 && o_quat.quat_y >= -16'sd16384
                 && o_quat.quat_z <= 16'sd16384 && o_quat.quat_z >= -16'sd16384))
        else $error("quaternion component out of range");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_out_zero) |-> (o_quat == '0))
        else $error("non-positive radicand gave nonzero result");

endmodule

// ===== dv/tb_rotation_matrix_to_quaternion_top.sv =====
// Testbench for rotation_matrix_to_quaternion_top: directed and random matrices
// checked against an in-bench fixed-point quaternion predictor. Depends on rmq_pkg.
`timescale 1ns / 100ps

class quat_scoreboard;
    rmq_pkg::t_out pending_quats[$];
    int            fail_count;

    function new();
        fail_count = 0;
    endfunction

    static function logic [15:0] root_q14(logic [31:0] v);
        logic [31:0] res;
        logic [31:0] bitv;
        res  = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[15:0];
    endfunction

    static function longint sat_q14(longint v);
        if (v > rmq_pkg::ONE_Q14) return rmq_pkg::ONE_Q14;
        if (v < -rmq_pkg::ONE_Q14) return -rmq_pkg::ONE_Q14;
        return v;
    endfunction

    // n*4096/big, round half away from zero
    static function longint scale_by_root(longint n, longint big);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = (mag * 8192 + big) / (2 * big);
        return sat_q14((n < 0) ? -q : q);
    endfunction

    function void note_matrix(rmq_pkg::t_in m);
        longint rx, ry, rz, ux, uy, uz, fx, fy, fz, tr, rad, big;
        longint num[4];
        logic [1:0] dom;
        rmq_pkg::t_out q;
        rx = m.right_x; ry = m.right_y; rz = m.right_z;
        ux = m.up_x;    uy = m.up_y;    uz = m.up_z;
        fx = m.fwd_x;   fy = m.fwd_y;   fz = m.fwd_z;
        tr = rx + uy + fz;
        if (tr > rmq_pkg::ONE_Q14) begin
            dom = rmq_pkg::DOM_W; rad = tr + rmq_pkg::ONE_Q14;
            num[1] = uz - fy; num[2] = fx - rz; num[3] = ry - ux;
        end else if (rx > uy && rx > fz) begin
            dom = rmq_pkg::DOM_X; rad = rmq_pkg::ONE_Q14 + rx - uy - fz;
            num[0] = uz - fy; num[2] = ry + ux; num[3] = rz + fx;
        end else if (uy > fz) begin
            dom = rmq_pkg::DOM_Y; rad = rmq_pkg::ONE_Q14 + uy - rx - fz;
            num[0] = fx - rz; num[1] = ry + ux; num[3] = uz + fy;
        end else begin
            dom = rmq_pkg::DOM_Z; rad = rmq_pkg::ONE_Q14 + fz - rx - uy;
            num[0] = ry - ux; num[1] = rz + fx; num[2] = uz + fy;
        end
        if (rad <= 0) begin
            q = '0;
        end else begin
            big = root_q14(32'(rad << 12));
            for (int i = 0; i < 4; i++)
                if (i == dom) num[i] = sat_q14(big);
                else num[i] = scale_by_root(num[i], big);
            q.quat_w = 16'(num[0]); q.quat_x = 16'(num[1]);
            q.quat_y = 16'(num[2]); q.quat_z = 16'(num[3]);
        end
        pending_quats.push_back(q);
    endfunction

    function void check_quat(rmq_pkg::t_out got);
        rmq_pkg::t_out exp;
        if (pending_quats.size() == 0) begin
            $error("result with no transaction pending");
            fail_count++;
            return;
        end
        exp = pending_quats.pop_front();
        if (got.quat_w !== exp.quat_w) begin
            $error("quat_w exp %0d got %0d", exp.quat_w, got.quat_w); fail_count++;
        end
        if (got.quat_x !== exp.quat_x) begin
            $error("quat_x exp %0d got %0d", exp.quat_x, got.quat_x); fail_count++;
        end
        if (got.quat_y !== exp.quat_y) begin
            $error("quat_y exp %0d got %0d", exp.quat_y, got.quat_y); fail_count++;
        end
        if (got.quat_z !== exp.quat_z) begin
            $error("quat_z exp %0d got %0d", exp.quat_z, got.quat_z); fail_count++;
        end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_DRAIN  = 40;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    rmq_pkg::t_in  i_in;
    logic          o_done;
    rmq_pkg::t_out o_quat;

    quat_scoreboard quats;
    int             cycle_count;
    int             idle_pct;

    rotation_matrix_to_quaternion_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_in   (i_in),
        .o_done (o_done),
        .o_quat (o_quat)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rotation_matrix_to_quaternion_top NOT OK");
            $finish;
        end
        if (i_rst_n && start && !busy) quats.note_matrix(i_in);
        if (i_rst_n && o_done) quats.check_quat(o_quat);
    end

    function automatic logic signed [15:0] any_elem();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (sel < 9) return 16'($urandom);
        return (sel[0]) ? 16'sd16384 : -16'sd16384;
    endfunction

    // rotation from a random unit quaternion, optionally with small noise
    function automatic rmq_pkg::t_in rot_matrix(bit noisy);
        real w, x, y, z, nrm;
        real e[9];
        rmq_pkg::t_in m;
        w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
        y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
        nrm = $sqrt(w*w + x*x + y*y + z*z);
        if (nrm < 1.0) begin
            w = 1.0; nrm = 1.0;
        end
        w /= nrm; x /= nrm; y /= nrm; z /= nrm;
        e[0] = 1 - 2*(y*y + z*z); e[1] = 2*(x*y + w*z); e[2] = 2*(x*z - w*y);
        e[3] = 2*(x*y - w*z); e[4] = 1 - 2*(x*x + z*z); e[5] = 2*(y*z + w*x);
        e[6] = 2*(x*z + w*y); e[7] = 2*(y*z - w*x); e[8] = 1 - 2*(x*x + y*y);
        for (int i = 0; i < 9; i++) begin
            e[i] = e[i] * 16384.0;
            if (noisy) e[i] += $urandom_range(0, 64) - 32.0;
        end
        m.right_x = 16'($rtoi(e[0])); m.right_y = 16'($rtoi(e[1]));
        m.right_z = 16'($rtoi(e[2])); m.up_x = 16'($rtoi(e[3]));
        m.up_y = 16'($rtoi(e[4])); m.up_z = 16'($rtoi(e[5]));
        m.fwd_x = 16'($rtoi(e[6])); m.fwd_y = 16'($rtoi(e[7]));
        m.fwd_z = 16'($rtoi(e[8]));
        return m;
    endfunction

    task automatic send_matrix(rmq_pkg::t_in m);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_diag(int a, int b, int c);
        rmq_pkg::t_in m;
        m = '0;
        m.right_x = 16'(a); m.up_y = 16'(b); m.fwd_z = 16'(c);
        send_matrix(m);
    endtask

    initial begin
        rmq_pkg::t_in m;
        int           pick;
        cycle_count = 0;
        idle_pct    = 0;
        quats       = new();
        start       = 1'b0;
        i_in        = '0;
        i_rst_n     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity (trace branch), each axis flip (x/y/z branches)
        send_diag(16384, 16384, 16384);
        send_diag(16384, -16384, -16384);
        send_diag(-16384, 16384, -16384);
        send_diag(-16384, -16384, 16384);
        send_diag(0, 0, 0);
        send_diag(-16384, -16384, -16384);
        send_diag(-32768, -32768, -32768);
        send_diag(32767, -32768, -32768);
        send_diag(16384, 16384, 0);
        m = '1;  send_matrix(m);
        m = '0;  send_matrix(m);
        m = {9{16'sh7fff}}; send_matrix(m);
        m = {9{16'sh8000}}; send_matrix(m);
        m = {9{16'sh5555}}; send_matrix(m);
        m = {9{16'shaaaa}}; send_matrix(m);
        // off-diagonal numerator cases; the second gives a huge quotient that saturates
        m = '0; m.right_x = -16'sd8192; m.up_y = 16'sd8192; m.fwd_z = 16'sd8191;
        m.up_z = 16'sd16384; m.fwd_y = -16'sd16384; send_matrix(m);
        m = '0; m.right_x = 16'sd1; m.up_y = 16'sd1; m.fwd_z = 16'sd1;
        m.right_y = 16'sh7fff; m.up_x = 16'sh8000; send_matrix(m);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 83 : (ph == 2) ? 0 : 27;
            for (int k = 0; k < 350; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) m = rot_matrix(pick > 3);
                else if (pick < 9) begin
                    m.right_x = any_elem(); m.right_y = any_elem();
                    m.right_z = any_elem(); m.up_x = any_elem();
                    m.up_y = any_elem(); m.up_z = any_elem();
                    m.fwd_x = any_elem(); m.fwd_y = any_elem();
                    m.fwd_z = any_elem();
                end else begin
                    m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
                end
                send_matrix(m);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (quats.pending_quats.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (quats.fail_count == 0) begin
            $display("tb_rotation_matrix_to_quaternion_top OK");
        end else begin
            $display("tb_rotation_matrix_to_quaternion_top NOT OK");
        end
        $finish;
    end
endmodule
